>>> design/dfs_pkg.sv
// ----------------------------------------------------------------------------
// dfs_pkg: shared types and constants for the depth-first edge classifier
// Holds the edge class codes and the sequencer state type.
// ----------------------------------------------------------------------------
package dfs_pkg;

    typedef enum logic [1:0] {
        CLASS_FORWARD = 2'd0,
        CLASS_BACK    = 2'd1,
        CLASS_CROSS   = 2'd2
    } edge_class_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_APPEND,
        ST_CLEAR,
        ST_ENTER,
        ST_TOP,
        ST_TOP_WAIT,
        ST_EDGE_WAIT,
        ST_VIS_WAIT,
        ST_OUT_NODE,
        ST_OUT_HEAD,
        ST_OUT_EDGE,
        ST_OUT_TIMES,
        ST_OUT_EMIT
    } seq_state_t;

endpackage

>>> design/dfs_edge_if.sv
// ----------------------------------------------------------------------------
// dfs_edge_if: valid/ready channel for input edges
// Carries one directed edge per beat.
// ----------------------------------------------------------------------------
interface dfs_edge_if;
    logic       valid;
    logic       ready;
    logic [5:0] source_node;
    logic [5:0] target_node;
    logic       last_edge;

    modport source (output valid, source_node, target_node, last_edge, input ready);
    modport sink   (input valid, source_node, target_node, last_edge, output ready);
endinterface

>>> design/dfs_result_if.sv
// ----------------------------------------------------------------------------
// dfs_result_if: valid/ready channel for classified edges
// Carries one classified edge per beat.
// ----------------------------------------------------------------------------
interface dfs_result_if;
    logic       valid;
    logic       ready;
    logic [5:0] edge_from;
    logic [5:0] edge_to;
    logic [1:0] edge_class;
    logic       last_result;

    modport source (output valid, edge_from, edge_to, edge_class, last_result, input ready);
    modport sink   (input valid, edge_from, edge_to, edge_class, last_result, output ready);
endinterface

>>> design/dfs_edge_classifier_top.sv
// ----------------------------------------------------------------------------
// dfs_edge_classifier_top: depth-first edge classifier
// Stores directed edges in per-node linked lists, runs an iterative depth-first
// walk on the last edge and streams out every stored edge with its class.
// ----------------------------------------------------------------------------
//  channel   | dir | beat contents
//  ----------+-----+----------------------------------------------
//  edge_in   | in  | source_node, target_node, last_edge
//  result    | out | edge_from, edge_to, edge_class, last_result
//  cfg       | in  | cfg_we, cfg_wdata (start_node)
//
//  Loading handles each edge as accept (edge write, tail read), then
//  append (head/tail write, old tail link). Before the walk a clearing pass over
//  all MAX_NODES entries wipes the time and visited memories.
//  The walk reads stack top, edge and target visited bit per edge examined,
//  enters and pops each reached node and ends on the empty stack; the output
//  sweep reads each node's head and each edge's times, held by any result stall.
//  rst_n clears control state and head/tail valid bits asynchronously.
//  A stalled result holds in the output register; no input is taken
//  during the append, the walk or the output sweep.
// ----------------------------------------------------------------------------
module dfs_edge_classifier_top #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    dfs_edge_if.sink    edge_in,
    dfs_result_if.source result
);
    import dfs_pkg::*;

    localparam int NW = (MAX_NODES > 64) ? $clog2(MAX_NODES) : 6;
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = EW + 1;          // edge count / link with room for null
    localparam int TW = 7;               // wrapping walk clock
    localparam int DW = $clog2(MAX_NODES) + 1;
    localparam int SW = $clog2(MAX_NODES);

    // ---------------- registers ----------------
    seq_state_t state_reg, state_next;
    logic [5:0]  start_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [TW-1:0] time_reg, time_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [SW-1:0] idx_reg, idx_next;        // clear sweep / output node index
    logic [NW-1:0] node_reg, node_next;      // node being entered or current top node
    logic [CW-1:0] cur_reg, cur_next;        // cursor of top / output edge
    logic [5:0]    to_reg, to_next;
    logic          any_reg, any_next;        // a result already waits in the staging
    logic          out_valid_reg;
    logic [5:0]    out_from_reg, out_to_reg;
    logic [1:0]    out_class_reg;
    logic          out_last_reg;

    // accepted edge held for the append cycle
    logic [NW-1:0] ap_src_reg;
    logic          ap_ok_reg;
    logic          ap_last_reg;

    // staged result before the output register (needed to flag the last one)
    logic [5:0]    stg_from_reg, stg_to_reg;
    logic [1:0]    stg_class_reg;

    // head/tail valid bits; the lists themselves live in memories
    logic [MAX_NODES-1:0] hv_reg;

    // memories
    logic [5:0]    tgt_mem  [MAX_EDGES];
    logic [CW-1:0] link_mem [MAX_EDGES];
    logic [CW-1:0] head_mem [MAX_NODES];
    logic [CW-1:0] tail_mem [MAX_NODES];
    logic [TW-1:0] ent_mem  [MAX_NODES];
    logic [TW-1:0] lev_mem  [MAX_NODES];
    logic          vis_mem  [MAX_NODES];
    logic [NW-1:0] stn_mem  [MAX_NODES];
    logic [CW-1:0] stc_mem  [MAX_NODES];

    // memory read data
    logic [5:0]    tgt_q;
    logic [CW-1:0] link_q;
    logic [CW-1:0] head_q;
    logic          head_v_q;
    logic [CW-1:0] tail_q;
    logic          vis_q;
    logic [NW-1:0] stn_q;
    logic [CW-1:0] stc_q;
    logic [TW-1:0] ent_a_q, lev_a_q, ent_b_q, lev_b_q;

    // memory controls
    logic          e_re;   logic [EW-1:0] e_ra;
    logic          l_we;   logic [EW-1:0] l_wa;  logic [CW-1:0] l_wd;
    logic          t_we;   logic [EW-1:0] t_wa;
    logic          v_re;   logic [NW-1:0] v_ra;
    logic          v_we;   logic [NW-1:0] v_wa;  logic v_wd;
    logic          en_we;  logic [NW-1:0] en_wa; logic [TW-1:0] en_wd;
    logic          lv_we;  logic [NW-1:0] lv_wa; logic [TW-1:0] lv_wd;
    logic          s_we;   logic [SW-1:0] s_wa;  logic [NW-1:0] s_wn; logic [CW-1:0] s_wc;
    logic          s_re;   logic [SW-1:0] s_ra;
    logic          tm_re;  logic [NW-1:0] tm_a,  tm_b;
    logic          h_re;   logic [NW-1:0] h_ra;
    logic          ht_we;
    logic          ht_clr;
    logic [CW-1:0] head_rd;

    logic          out_free;
    logic          in_fire;
    logic          store_ok;
    logic [NW-1:0] in_src;
    logic          push_stg;
    logic          push_last;
    logic [CW-1:0] null_link;
    logic [1:0]    cls;

    assign null_link = '1;
    assign out_free  = !out_valid_reg || result.ready;
    assign edge_in.ready = (state_reg == ST_LOAD);
    assign in_fire   = edge_in.valid && edge_in.ready;
    assign in_src    = NW'(edge_in.source_node);
    assign store_ok  = (count_reg < CW'(MAX_EDGES))
                       && (32'(edge_in.source_node) < MAX_NODES)
                       && (32'(edge_in.target_node) < MAX_NODES);
    assign ht_we     = (state_reg == ST_APPEND) && ap_ok_reg;
    assign head_rd   = head_v_q ? head_q : null_link;

    assign result.valid       = out_valid_reg;
    assign result.edge_from   = out_from_reg;
    assign result.edge_to     = out_to_reg;
    assign result.edge_class  = out_class_reg;
    assign result.last_result = out_last_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_reg <= '0;
        else if (cfg_we)
            start_reg <= cfg_wdata;
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (t_we)
            tgt_mem[t_wa] <= edge_in.target_node;
        if (l_we)
            link_mem[l_wa] <= l_wd;
        if (e_re)
        begin
            tgt_q  <= tgt_mem[e_ra];
            link_q <= link_mem[e_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            vis_mem[v_wa] <= v_wd;
        if (v_re)
            vis_q <= vis_mem[v_ra];
        if (en_we)
            ent_mem[en_wa] <= en_wd;
        if (lv_we)
            lev_mem[lv_wa] <= lv_wd;
        if (tm_re)
        begin
            ent_a_q <= ent_mem[tm_a];
            lev_a_q <= lev_mem[tm_a];
            ent_b_q <= ent_mem[tm_b];
            lev_b_q <= lev_mem[tm_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            stn_mem[s_wa] <= s_wn;
            stc_mem[s_wa] <= s_wc;
        end
        if (s_re)
        begin
            stn_q <= stn_mem[s_ra];
            stc_q <= stc_mem[s_ra];
        end
    end

    // ---------------- head / tail memories ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hv_reg <= '0;
        else if (ht_clr)
            hv_reg <= '0;
        else if (ht_we)
            hv_reg[ap_src_reg] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ht_we)
        begin
            tail_mem[ap_src_reg] <= count_reg;
            if (!hv_reg[ap_src_reg])
                head_mem[ap_src_reg] <= count_reg;
        end
        if (in_fire)
            tail_q <= tail_mem[in_src];
        if (h_re)
        begin
            head_q   <= head_mem[h_ra];
            head_v_q <= hv_reg[h_ra];
        end
    end

    // ---------------- sequencer registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            time_reg  <= '0;
            depth_reg <= '0;
            idx_reg   <= '0;
            any_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            time_reg  <= time_next;
            depth_reg <= depth_next;
            idx_reg   <= idx_next;
            any_reg   <= any_next;
            if (push_stg || push_last)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        cur_reg  <= cur_next;
        to_reg   <= to_next;
        if (in_fire)
        begin
            ap_src_reg  <= in_src;
            ap_ok_reg   <= store_ok;
            ap_last_reg <= edge_in.last_edge;
        end
        if (push_stg || push_last)
        begin
            out_from_reg  <= stg_from_reg;
            out_to_reg    <= stg_to_reg;
            out_class_reg <= stg_class_reg;
            out_last_reg  <= push_last;
        end
        if (state_reg == ST_OUT_EMIT && out_free)
        begin
            stg_from_reg  <= 6'(node_reg);
            stg_to_reg    <= to_reg;
            stg_class_reg <= cls;
        end
    end

    // class of the edge whose times were just read
    always_comb
    begin
        if (ent_a_q < ent_b_q && lev_a_q > lev_b_q)
            cls = CLASS_FORWARD;
        else if (ent_b_q < ent_a_q && lev_b_q > lev_a_q)
            cls = CLASS_BACK;
        else
            cls = CLASS_CROSS;
    end

    // ---------------- next state and controls ----------------
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        time_next  = time_reg;
        depth_next = depth_reg;
        idx_next   = idx_reg;
        node_next  = node_reg;
        cur_next   = cur_reg;
        to_next    = to_reg;
        any_next   = any_reg;
        push_stg   = 1'b0;
        push_last  = 1'b0;
        ht_clr     = 1'b0;
        h_re       = 1'b0;
        h_ra       = node_reg;
        e_re = 1'b0; e_ra = EW'(cur_reg);
        l_we = 1'b0; l_wa = '0; l_wd = null_link;
        t_we = 1'b0; t_wa = '0;
        v_re = 1'b0; v_ra = NW'(to_reg);
        v_we = 1'b0; v_wa = node_reg; v_wd = 1'b1;
        en_we = 1'b0; en_wa = node_reg; en_wd = time_reg;
        lv_we = 1'b0; lv_wa = node_reg; lv_wd = time_reg;
        s_we = 1'b0; s_wa = SW'(depth_reg); s_wn = node_reg; s_wc = cur_reg;
        s_re = 1'b0; s_ra = SW'(depth_reg - DW'(1));
        tm_re = 1'b0; tm_a = node_reg; tm_b = NW'(to_reg);

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (store_ok)
                    begin
                        // write the edge with a null link; tail read is under way
                        t_we = 1'b1; t_wa = EW'(count_reg);
                        l_we = 1'b1; l_wa = EW'(count_reg); l_wd = null_link;
                    end
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                if (ap_ok_reg)
                begin
                    // link the old tail to the new edge
                    if (hv_reg[ap_src_reg])
                    begin
                        l_we = 1'b1; l_wa = EW'(tail_q); l_wd = count_reg;
                    end
                    count_next = count_reg + CW'(1);
                end
                if (ap_last_reg)
                begin
                    state_next = ST_CLEAR;
                    idx_next   = '0;
                end
                else
                    state_next = ST_LOAD;
            end
            ST_CLEAR:
            begin
                v_we = 1'b1; v_wa = NW'(idx_reg); v_wd = 1'b0;
                en_we = 1'b1; en_wa = NW'(idx_reg); en_wd = '0;
                lv_we = 1'b1; lv_wa = NW'(idx_reg); lv_wd = '0;
                idx_next = idx_reg + SW'(1);
                if (32'(idx_reg) == MAX_NODES - 1)
                begin
                    time_next  = '0;
                    depth_next = '0;
                    idx_next   = '0;
                    node_next  = NW'(start_reg);
                    h_re       = 1'b1;
                    h_ra       = NW'(start_reg);
                    if (32'(start_reg) < MAX_NODES && count_reg != '0)
                        state_next = ST_ENTER;
                    else if (32'(start_reg) < MAX_NODES)
                    begin
                        // no edges: walk is invisible, nothing to emit
                        state_next = ST_OUT_NODE;
                    end
                    else
                        state_next = ST_OUT_NODE;
                end
            end
            ST_ENTER:
            begin
                // mark, stamp and push node_reg
                v_we = 1'b1; v_wd = 1'b1;
                en_we = 1'b1; en_wd = time_reg;
                time_next = time_reg + TW'(1);
                s_we = 1'b1; s_wn = node_reg; s_wc = head_rd;
                depth_next = depth_reg + DW'(1);
                state_next = ST_TOP;
            end
            ST_TOP:
            begin
                if (depth_reg == '0)
                begin
                    state_next = ST_OUT_NODE;
                    idx_next   = '0;
                end
                else
                begin
                    s_re = 1'b1;
                    state_next = ST_TOP_WAIT;
                end
            end
            ST_TOP_WAIT:
            begin
                node_next = stn_q;
                cur_next  = stc_q;
                if (stc_q >= count_reg || 32'(stc_q) >= MAX_EDGES)
                begin
                    lv_we = 1'b1; lv_wa = stn_q; lv_wd = time_reg;
                    time_next  = time_reg + TW'(1);
                    depth_next = depth_reg - DW'(1);
                    state_next = ST_TOP;
                end
                else
                begin
                    e_re = 1'b1; e_ra = EW'(stc_q);
                    state_next = ST_EDGE_WAIT;
                end
            end
            ST_EDGE_WAIT:
            begin
                // advance the top cursor, probe target
                s_we = 1'b1; s_wa = SW'(depth_reg - DW'(1));
                s_wn = node_reg; s_wc = link_q;
                to_next = tgt_q;
                v_re = 1'b1; v_ra = NW'(tgt_q);
                state_next = ST_VIS_WAIT;
            end
            ST_VIS_WAIT:
            begin
                if (!vis_q)
                begin
                    node_next  = NW'(to_reg);
                    h_re       = 1'b1;
                    h_ra       = NW'(to_reg);
                    state_next = ST_ENTER;
                end
                else
                    state_next = ST_TOP;
            end
            ST_OUT_NODE:
            begin
                node_next = NW'(idx_reg);
                h_re      = 1'b1;
                h_ra      = NW'(idx_reg);
                state_next = ST_OUT_HEAD;
            end
            ST_OUT_HEAD:
            begin
                cur_next = head_rd;
                state_next = ST_OUT_EDGE;
            end
            ST_OUT_EDGE:
            begin
                if (cur_reg >= count_reg || 32'(cur_reg) >= MAX_EDGES)
                begin
                    idx_next = idx_reg + SW'(1);
                    if (32'(idx_reg) == MAX_NODES - 1)
                    begin
                        // flush the held result as the last one
                        if (any_reg)
                        begin
                            if (out_free)
                            begin
                                push_last  = 1'b1;
                                any_next   = 1'b0;
                                ht_clr     = 1'b1;
                                count_next = '0;
                                idx_next   = '0;
                                state_next = ST_LOAD;
                            end
                            else
                                idx_next = idx_reg;
                        end
                        else
                        begin
                            ht_clr     = 1'b1;
                            count_next = '0;
                            idx_next   = '0;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                        state_next = ST_OUT_NODE;
                end
                else
                begin
                    e_re = 1'b1; e_ra = EW'(cur_reg);
                    state_next = ST_OUT_TIMES;
                end
            end
            ST_OUT_TIMES:
            begin
                to_next  = tgt_q;
                cur_next = link_q;
                tm_re = 1'b1; tm_a = node_reg; tm_b = NW'(tgt_q);
                state_next = ST_OUT_EMIT;
            end
            ST_OUT_EMIT:
            begin
                if (out_free)
                begin
                    push_stg   = any_reg;
                    any_next   = 1'b1;
                    state_next = ST_OUT_EDGE;
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    // ---------------- assertions ----------------
    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !edge_in.ready)
        else $error("input taken outside load phase");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_EDGES)
        else $error("edge count overflow");
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= MAX_NODES)
        else $error("walk stack overflow");
    a_load_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !any_reg)
        else $error("staged result left behind");

endmodule
